// ===== design/idrp_pkg.sv =====
package idrp_pkg;

    localparam int POS_W = 25;
    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam logic [POS_W-1:0] DIR_LEN_RESET = 25'd2048;

    localparam logic [7:0] MIN_RECORD  = 8'd34;
    localparam logic [7:0] NAME_START  = 8'd33;
    localparam logic [7:0] NAME_LEN_AT = 8'd32;
    localparam logic [7:0] SIZE_AT     = 8'd10;
    localparam logic [7:0] FLAGS_AT    = 8'd25;
    localparam logic [7:0] EXTENT_LO   = 8'd2;
    localparam logic [7:0] EXTENT_HI   = 8'd5;
    localparam logic [7:0] SEMICOLON   = 8'h3b;

    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    localparam logic REG_DIR_LEN = 1'b0;

    typedef enum logic {
        KIND_CHAR  = 1'b0,
        KIND_ENTRY = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  name_char;
        logic [31:0] extent;
        logic [31:0] file_size;
        logic        is_directory;
        logic [7:0]  name_length;
    } result_t;

    typedef struct packed {
        logic w0;
        logic w1;
    } push_t;

endpackage

// ===== design/idrp_if.sv =====
interface idrp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface idrp_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  name_char;
    logic [31:0] extent;
    logic [31:0] file_size;
    logic        is_directory;
    logic [7:0]  name_length;

    modport source (output valid, output kind, output name_char, output extent,
                    output file_size, output is_directory, output name_length,
                    input ready);
    modport sink (input valid, input kind, input name_char, input extent,
                  input file_size, input is_directory, input name_length,
                  output ready);
endinterface

// ===== design/idrp_parse.sv =====
module idrp_parse #(
    parameter int SECTOR_BYTES = 2048
) (
    input  logic                       clk,
    input  logic                       rst_n,
    idrp_byte_if.sink                  bytes_in,
    input  logic [idrp_pkg::POS_W-1:0] directory_length,
    input  logic                       room,
    output idrp_pkg::push_t            push,
    output idrp_pkg::result_t          res0,
    output idrp_pkg::result_t          res1
);
    import idrp_pkg::*;

    localparam int SEC_W = $clog2(SECTOR_BYTES);
    localparam logic [SEC_W-1:0] SEC_LAST = SEC_W'(SECTOR_BYTES - 1);

    // input register
    logic       stg_valid_reg;
    logic [7:0] stg_byte_reg;
    logic       stg_first_reg;
    logic       stage_fire;

    // parse state
    logic [POS_W-1:0] pos_reg, pos_next, e_pos;
    logic [SEC_W-1:0] sec_reg, sec_next, e_sec;
    logic [7:0]  off_reg, off_next, e_off;
    logic [7:0]  rlen_reg, rlen_next, e_rlen;
    logic [7:0]  idl_reg, idl_next, e_idl;
    logic [7:0]  cnt_reg, cnt_next, e_cnt;
    logic        semi_reg, semi_next, e_semi;
    logic        dot_reg, dot_next, e_dot;
    logic [31:0] ext_reg, ext_next, e_ext;
    logic [31:0] size_reg, size_next, e_size;
    logic        dirf_reg, dirf_next, e_dirf;
    logic        pad_reg, pad_next, e_pad;
    logic        stop_reg, stop_next, e_stop;

    logic       dot_v;
    logic       char_hit;
    logic       entry_hit;
    logic [7:0] b;
    result_t    char_res;
    result_t    entry_res;

    assign stage_fire     = stg_valid_reg && room;
    assign bytes_in.ready = !stg_valid_reg || room;
    assign b              = stg_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (bytes_in.ready)
        begin
            stg_valid_reg <= bytes_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes_in.ready && bytes_in.valid)
        begin
            stg_byte_reg  <= bytes_in.data_byte;
            stg_first_reg <= bytes_in.first_byte;
        end
    end

    // a first byte clears the parse state before it is used
    always_comb
    begin
        if (stg_first_reg)
        begin
            e_pos  = '0;
            e_sec  = '0;
            e_off  = '0;
            e_rlen = '0;
            e_idl  = '0;
            e_cnt  = '0;
            e_semi = 1'b0;
            e_dot  = 1'b0;
            e_ext  = '0;
            e_size = '0;
            e_dirf = 1'b0;
            e_pad  = 1'b0;
            e_stop = 1'b0;
        end
        else
        begin
            e_pos  = pos_reg;
            e_sec  = sec_reg;
            e_off  = off_reg;
            e_rlen = rlen_reg;
            e_idl  = idl_reg;
            e_cnt  = cnt_reg;
            e_semi = semi_reg;
            e_dot  = dot_reg;
            e_ext  = ext_reg;
            e_size = size_reg;
            e_dirf = dirf_reg;
            e_pad  = pad_reg;
            e_stop = stop_reg;
        end
    end

    always_comb
    begin
        off_next  = e_off;
        rlen_next = e_rlen;
        idl_next  = e_idl;
        cnt_next  = e_cnt;
        semi_next = e_semi;
        dot_next  = e_dot;
        ext_next  = e_ext;
        size_next = e_size;
        dirf_next = e_dirf;
        pad_next  = e_pad;
        stop_next = e_stop;
        dot_v     = e_dot;
        char_hit  = 1'b0;
        entry_hit = 1'b0;

        if (e_pos == POS_MAX)
        begin
            pos_next = e_pos;
            sec_next = e_sec;
        end
        else
        begin
            pos_next = e_pos + 1'b1;
            sec_next = (e_sec == SEC_LAST) ? '0 : e_sec + 1'b1;
        end

        if (!e_stop && (e_pos < directory_length) && !(e_pad && (e_sec != '0)))
        begin
            pad_next = 1'b0;
            if (e_off == 8'd0)
            begin
                if (b == 8'd0)
                begin
                    pad_next = 1'b1;
                end
                else if ((b < MIN_RECORD) ||
                         (({1'b0, e_pos} + (POS_W + 1)'(b)) > {1'b0, directory_length}))
                begin
                    stop_next = 1'b1;
                end
                else
                begin
                    rlen_next = b;
                    off_next  = 8'd1;
                    idl_next  = '0;
                    cnt_next  = '0;
                    semi_next = 1'b0;
                    dot_next  = 1'b0;
                    ext_next  = '0;
                    size_next = '0;
                    dirf_next = 1'b0;
                end
            end
            else
            begin
                if (e_off inside {[EXTENT_LO:EXTENT_HI]})
                begin
                    ext_next = {b, e_ext[31:8]};
                end
                else if (e_off inside {[SIZE_AT:SIZE_AT + 8'd3]})
                begin
                    size_next = {b, e_size[31:8]};
                end
                else if (e_off == FLAGS_AT)
                begin
                    dirf_next = b[1];
                end
                else if (e_off == NAME_LEN_AT)
                begin
                    idl_next = b;
                end

                // name overruns the record
                if ((e_off == NAME_LEN_AT) &&
                    (({1'b0, NAME_START} + {1'b0, b}) > {1'b0, e_rlen}))
                begin
                    stop_next = 1'b1;
                    off_next  = 8'd0;
                end
                else
                begin
                    dot_v    = e_dot ||
                               ((e_off == NAME_START) && (e_idl == 8'd1) && (b <= 8'd1));
                    dot_next = dot_v;
                    if ((e_off >= NAME_START) &&
                        ({1'b0, e_off} < ({1'b0, NAME_START} + {1'b0, e_idl})) &&
                        !dot_v && !e_semi)
                    begin
                        if (b == SEMICOLON)
                        begin
                            semi_next = 1'b1;
                        end
                        else
                        begin
                            char_hit = 1'b1;
                            cnt_next = e_cnt + 8'd1;
                        end
                    end
                    if (({1'b0, e_off} + 9'd1) >= {1'b0, e_rlen})
                    begin
                        entry_hit = !dot_v;
                        off_next  = 8'd0;
                    end
                    else
                    begin
                        off_next = e_off + 8'd1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        char_res              = '0;
        char_res.kind         = KIND_CHAR;
        char_res.name_char    = b;
        entry_res             = '0;
        entry_res.kind        = KIND_ENTRY;
        entry_res.extent      = ext_next;
        entry_res.file_size   = size_next;
        entry_res.is_directory = dirf_next;
        entry_res.name_length = cnt_next;
    end

    assign res0    = char_hit ? char_res : entry_res;
    assign res1    = entry_res;
    assign push.w0 = stage_fire && (char_hit || entry_hit);
    assign push.w1 = stage_fire && char_hit && entry_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            sec_reg  <= '0;
            off_reg  <= '0;
            rlen_reg <= '0;
            idl_reg  <= '0;
            cnt_reg  <= '0;
            semi_reg <= 1'b0;
            dot_reg  <= 1'b0;
            ext_reg  <= '0;
            size_reg <= '0;
            dirf_reg <= 1'b0;
            pad_reg  <= 1'b0;
            stop_reg <= 1'b0;
        end
        else if (stage_fire)
        begin
            pos_reg  <= pos_next;
            sec_reg  <= sec_next;
            off_reg  <= off_next;
            rlen_reg <= rlen_next;
            idl_reg  <= idl_next;
            cnt_reg  <= cnt_next;
            semi_reg <= semi_next;
            dot_reg  <= dot_next;
            ext_reg  <= ext_next;
            size_reg <= size_next;
            dirf_reg <= dirf_next;
            pad_reg  <= pad_next;
            stop_reg <= stop_next;
        end
    end

    a_stopped_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (stg_valid_reg && stop_reg && !stg_first_reg) |-> !push.w0)
        else $error("result pushed while parsing is stopped");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.w1 |-> (res0.kind == KIND_CHAR) && (res1.kind == KIND_ENTRY))
        else $error("result pair out of order");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (stg_valid_reg && !room) |=> (stg_valid_reg && $stable(stg_byte_reg)))
        else $error("stalled input word changed");

endmodule

// ===== design/idrp_resq.sv =====
module idrp_resq (
    input  logic              clk,
    input  logic              rst_n,
    input  idrp_pkg::push_t   push,
    input  idrp_pkg::result_t res0,
    input  idrp_pkg::result_t res1,
    output logic              room,
    idrp_result_if.source     results
);
    import idrp_pkg::*;

    result_t                mem_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0]   wptr_reg, wptr_next;
    logic [RES_PTR_W-1:0]   rptr_reg, rptr_next;
    logic [RES_CNT_W-1:0]   count_reg, count_next;
    logic                   pop;
    result_t                head;

    assign pop  = results.valid && results.ready;
    assign room = count_reg <= RES_CNT_W'(RES_DEPTH - 2);
    assign head = mem_reg[rptr_reg];

    assign results.valid        = count_reg != '0;
    assign results.kind         = head.kind;
    assign results.name_char    = head.name_char;
    assign results.extent       = head.extent;
    assign results.file_size    = head.file_size;
    assign results.is_directory = head.is_directory;
    assign results.name_length  = head.name_length;

    always_comb
    begin
        wptr_next  = wptr_reg + RES_PTR_W'(push.w0) + RES_PTR_W'(push.w1);
        rptr_next  = rptr_reg + RES_PTR_W'(pop);
        count_next = count_reg + RES_CNT_W'(push.w0) + RES_CNT_W'(push.w1)
                     - RES_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.w0)
        begin
            mem_reg[wptr_reg] <= res0;
        end
        if (push.w1)
        begin
            mem_reg[wptr_reg + RES_PTR_W'(1)] <= res1;
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= RES_CNT_W'(RES_DEPTH))
        else $error("result queue overfilled");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.w0 |-> count_reg <= RES_CNT_W'(RES_DEPTH - 2))
        else $error("push without room for a result pair");

    a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.ready) |=> (results.valid && $stable(head)))
        else $error("waiting result word changed");

endmodule

// ===== design/iso9660_directory_record_parser_core.sv =====
// channel     dir  handshake      payload
// bytes_in    in   valid/ready    data_byte, first_byte
// results     out  valid/ready    kind, name_char, extent, file_size, is_directory, name_length
// apb         in   psel/penable   directory_length at address 0
//
// one byte per cycle while the result queue has room; a byte is parsed while it sits in the input register
// a byte gives at most two words; they land in a four-entry result queue
// input stalls only while the queue has room for fewer than two words
// rst_n clears all parse state and sets directory_length to 2048
module iso9660_directory_record_parser_core #(
    parameter int SECTOR_BYTES = 2048
) (
    input  logic          clk,
    input  logic          rst_n,
    idrp_byte_if.sink     bytes_in,
    idrp_result_if.source results,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import idrp_pkg::*;

    logic [POS_W-1:0] dir_len_reg;
    logic             room;
    push_t            push;
    result_t          res0;
    result_t          res1;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DIR_LEN) ? {{(32 - POS_W){1'b0}}, dir_len_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_len_reg <= DIR_LEN_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_DIR_LEN))
        begin
            dir_len_reg <= pwdata[POS_W-1:0];
        end
    end

    idrp_parse #(
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_parse (
        .clk              (clk),
        .rst_n            (rst_n),
        .bytes_in         (bytes_in),
        .directory_length (dir_len_reg),
        .room             (room),
        .push             (push),
        .res0             (res0),
        .res1             (res1)
    );

    idrp_resq u_resq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .res0    (res0),
        .res1    (res1),
        .room    (room),
        .results (results)
    );

endmodule
